FILE: design/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// types, constants and helpers shared by the sorted record table
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int NAME_LEN = 20;
  localparam int NAME_W   = NAME_LEN * 8;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_DISPLAY = 2'd1,
    REQ_LOOKUP  = 2'd2,
    REQ_DELETE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_WR,
    S_SCAN,
    S_DISP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] code;
    logic [63:0]        name_bytes_0_7;
    logic [63:0]        name_bytes_8_15;
    logic [31:0]        name_bytes_16_19;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_code;
    logic [63:0]        entry_name_0_7;
    logic [63:0]        entry_name_8_15;
    logic [31:0]        entry_name_16_19;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [31:0]       code;
    logic [NAME_W-1:0] name;
  } rec_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;
  } mem_req_t;

  // zero every byte after the first zero byte
  function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] r;
    logic              ended;
    r     = n;
    ended = 1'b0;
    for (int i = 0; i < NAME_LEN; i++) begin
      if (ended) begin
        r[NAME_W-1-8*i -: 8] = 8'h00;
      end else if (n[NAME_W-1-8*i -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic out_item_t make_item(input status_t st, input rec_t r,
                                          input logic lst);
    out_item_t o;
    o.status           = st;
    o.entry_code       = signed'(r.code);
    o.entry_name_0_7   = r.name[NAME_W-1 -: 64];
    o.entry_name_8_15  = r.name[NAME_W-65 -: 64];
    o.entry_name_16_19 = r.name[31:0];
    o.last             = lst;
    return o;
  endfunction

endpackage

FILE: design/srt_mem.sv
// ----------------------------------------------------------------------------
// srt_mem
// record store, one write port and one registered read port
// ----------------------------------------------------------------------------
module srt_mem
  import srt_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output rec_t     rd_data
);

  rec_t mem_r [CAPACITY];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/srt_seq.sv
// ----------------------------------------------------------------------------
// srt_seq
// sequencer: scans, shifts and reports records through the record store
// ----------------------------------------------------------------------------
module srt_seq
  import srt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  logic      slot_free,
  output logic      push,
  output out_item_t push_item,
  output mem_req_t  mem_req,
  input  rec_t      rd_rec
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  rec_t              rec_r, rec_nxt;
  logic [1:0]        op_r, op_nxt;
  logic              found_r, found_nxt;
  out_item_t         res_r, res_nxt;

  rec_t              zero_rec;
  rec_t              in_rec;
  logic [CNT_W-1:0]  idx_ext;
  logic              at_last;
  logic              idx_zero;
  logic              ge_new;
  logic              code_hit;
  logic              is_full;
  logic              is_empty;
  logic [IDX_W-1:0]  top_idx;

  assign zero_rec    = '0;
  assign in_rec.code = in_data.code;
  assign in_rec.name = clean_name({in_data.name_bytes_0_7, in_data.name_bytes_8_15,
                                   in_data.name_bytes_16_19});
  assign idx_ext   = CNT_W'(idx_r);
  assign at_last   = (idx_ext + CNT_W'(1)) == count_r;
  assign idx_zero  = idx_r == '0;
  assign ge_new    = rd_rec.name >= rec_r.name;
  assign code_hit  = rd_rec.code == rec_r.code;
  assign is_full   = count_r == CNT_W'(CAPACITY);
  assign is_empty  = count_r == '0;
  assign top_idx   = IDX_W'(count_r - CNT_W'(1));

  // next state and working registers
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    rec_nxt   = rec_r;
    op_nxt    = op_r;
    found_nxt = found_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rec_nxt   = in_rec;
          op_nxt    = in_data.req_type;
          found_nxt = 1'b0;
          idx_nxt   = '0;
          res_nxt   = make_item(ST_NOT_FOUND, zero_rec, 1'b1);
          if (in_data.req_type == REQ_INSERT) begin
            if (is_full) begin
              res_nxt   = make_item(ST_FULL, zero_rec, 1'b1);
              state_nxt = S_FIN;
            end else if (is_empty) begin
              pos_nxt   = '0;
              state_nxt = S_INS_WR;
            end else begin
              idx_nxt   = top_idx;
              state_nxt = S_INS_CMP;
            end
          end else if (is_empty) begin
            res_nxt   = make_item(ST_EMPTY, zero_rec, 1'b1);
            state_nxt = S_FIN;
          end else if (in_data.req_type == REQ_DISPLAY) begin
            state_nxt = S_DISP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_INS_CMP: begin
        if (ge_new) begin
          if (idx_zero) begin
            pos_nxt   = '0;
            state_nxt = S_INS_WR;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end else begin
          pos_nxt   = IDX_W'(idx_r + IDX_W'(1));
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        res_nxt   = make_item(ST_OK, rec_r, 1'b1);
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_FIN;
      end
      S_DISP: begin
        if (slot_free) begin
          if (at_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      S_SCAN: begin
        if (!found_r && code_hit) begin
          found_nxt = 1'b1;
          res_nxt   = make_item(ST_OK, rd_rec, 1'b1);
        end
        if (at_last || (op_r == REQ_LOOKUP && code_hit)) begin
          state_nxt = S_FIN;
          if (op_r == REQ_DELETE && (found_r || code_hit)) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_FIN: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // memory requests, result push and input stall
  always_comb begin
    mem_req   = '0;
    push      = 1'b0;
    push_item = res_r;
    in_stall  = state_r != S_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !is_empty &&
            !(in_data.req_type == REQ_INSERT && is_full)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = (in_data.req_type == REQ_INSERT) ? top_idx : '0;
        end
      end
      S_INS_CMP: begin
        if (ge_new) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = IDX_W'(idx_r + IDX_W'(1));
          mem_req.wr_data = rd_rec;
          if (!idx_zero) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_r - IDX_W'(1);
          end
        end
      end
      S_INS_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_r;
        mem_req.wr_data = rec_r;
      end
      S_DISP: begin
        push_item = make_item(ST_OK, rd_rec, at_last);
        if (slot_free) begin
          push = 1'b1;
          if (!at_last) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_r + IDX_W'(1);
          end
        end
      end
      S_SCAN: begin
        if (found_r && op_r == REQ_DELETE) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = idx_r - IDX_W'(1);
          mem_req.wr_data = rd_rec;
        end
        if (!(at_last || (op_r == REQ_LOOKUP && code_hit))) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_r + IDX_W'(1);
        end
      end
      S_FIN: begin
        push = slot_free;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    rec_r <= rec_nxt;
    op_r  <= op_nxt;
    res_r <= res_nxt;
  end

endmodule

FILE: design/sorted_record_table.sv
// ----------------------------------------------------------------------------
// sorted_record_table
// table of up to CAPACITY records kept in ascending name order
// insert, lookup, delete and display read the store once per entry scanned;
//   an insert into a full table scans no entries
// throughput: one item at a time; the next is taken once the last result
//   has entered the output register
// reset: synchronous, clears the entry count; the store needs no clearing
// ----------------------------------------------------------------------------
module sorted_record_table
  import srt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  mem_req_t  mem_req;
  rec_t      rd_rec;
  logic      slot_free;
  logic      push;
  out_item_t push_item;
  logic      out_valid_r;
  out_item_t out_data_r;

  assign slot_free = !out_valid_r || !out_stall;

  srt_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_rec)
  );

  srt_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .slot_free (slot_free),
    .push      (push),
    .push_item (push_item),
    .mem_req   (mem_req),
    .rd_rec    (rd_rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= push_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
